[src/spts_pkg.sv]
// Package for the signal priority task scheduler: sizes, mode codes,
// item and result structs, and the priority encoder. No dependencies.
`default_nettype none

package spts_pkg;

    localparam int MAX_TASKS   = 32;
    localparam int SIGNAL_BITS = 16;
    localparam int TASK_W      = $clog2(MAX_TASKS);
    localparam int MODE_W      = 3;

    localparam logic [MODE_W-1:0] MODE_START    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SEND     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WAIT     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ_RX  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_EX  = 3'd5;

    typedef logic [TASK_W-1:0]      task_idx_t;
    typedef logic [SIGNAL_BITS-1:0] sig_word_t;
    typedef logic [MAX_TASKS-1:0]   task_map_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        task_idx_t         target_task;
        sig_word_t         signal_mask;
    } item_t;

    typedef struct packed {
        task_idx_t running_task;
        logic      switched;
        logic      blocked;
        logic      none_ready;
        sig_word_t flags_out;
    } result_t;

    // Lowest set bit wins; zero input gives zero.
    function automatic task_idx_t first_set(input task_map_t v);
        task_idx_t idx;
        idx = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = TASK_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

[src/spts_sched_core.sv]
// Task table, ready map and running index, with the per-item update logic.
// Depends on spts_pkg.
`default_nettype none

module spts_sched_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire spts_pkg::item_t   item,
    input  wire spts_pkg::task_idx_t task_count,
    output spts_pkg::result_t      result
);

    spts_pkg::sig_word_t  rx_reg [spts_pkg::MAX_TASKS];
    spts_pkg::sig_word_t  ex_reg [spts_pkg::MAX_TASKS];
    spts_pkg::task_map_t  ready_reg;
    spts_pkg::task_map_t  ready_next;
    spts_pkg::task_idx_t  cur_reg;
    spts_pkg::task_idx_t  cur_next;

    spts_pkg::task_idx_t  rd_idx;
    spts_pkg::sig_word_t  rx_rd;
    spts_pkg::sig_word_t  ex_rd;
    spts_pkg::sig_word_t  rx_wdata;
    spts_pkg::sig_word_t  ex_wdata;
    logic                 rx_we;
    logic                 ex_we;
    logic                 clear_all;
    spts_pkg::task_map_t  ready_drop;
    spts_pkg::task_map_t  elig;
    spts_pkg::task_map_t  elig_mask;
    spts_pkg::task_map_t  target_bit;
    spts_pkg::task_map_t  cur_bit;
    logic                 blocked;
    logic                 none_ready;
    spts_pkg::sig_word_t  flags;

    assign rd_idx = (item.mode == spts_pkg::MODE_SEND || item.mode == spts_pkg::MODE_READ_EX)
                    ? item.target_task : cur_reg;
    assign rx_rd  = rx_reg[rd_idx];
    assign ex_rd  = ex_reg[rd_idx];

    assign target_bit = spts_pkg::task_map_t'(1) << item.target_task;
    assign cur_bit    = spts_pkg::task_map_t'(1) << cur_reg;
    assign elig_mask  = {spts_pkg::MAX_TASKS{1'b1}}
                        >> (spts_pkg::TASK_W'(spts_pkg::MAX_TASKS - 1) - task_count);
    assign ready_drop = ready_reg & ~cur_bit;
    assign elig       = ready_drop & elig_mask;

    always_comb
    begin
        ready_next = ready_reg;
        cur_next   = cur_reg;
        rx_we      = 1'b0;
        ex_we      = 1'b0;
        rx_wdata   = rx_rd;
        ex_wdata   = '0;
        clear_all  = 1'b0;
        blocked    = 1'b0;
        none_ready = 1'b0;
        flags      = '0;
        case (item.mode)
            spts_pkg::MODE_START:
            begin
                clear_all  = 1'b1;
                ready_next = elig_mask;
                cur_next   = '0;
            end
            spts_pkg::MODE_SEND:
            begin
                if (item.target_task <= task_count) begin
                    rx_we    = 1'b1;
                    rx_wdata = rx_rd | item.signal_mask;
                    flags    = rx_wdata;
                    if ((rx_wdata & ex_rd) != '0) begin
                        ready_next = ready_reg | target_bit;
                        ex_we      = 1'b1;
                        if (item.target_task < cur_reg) begin
                            cur_next = item.target_task;
                        end
                    end
                end
            end
            spts_pkg::MODE_WAIT:
            begin
                flags = rx_rd;
                if ((rx_rd & item.signal_mask) == '0) begin
                    ex_we      = 1'b1;
                    ex_wdata   = item.signal_mask;
                    ready_next = ready_drop;
                    blocked    = 1'b1;
                    if (elig == '0) begin
                        none_ready = 1'b1;
                        cur_next   = task_count;
                    end
                    else begin
                        cur_next = spts_pkg::first_set(elig);
                    end
                end
            end
            spts_pkg::MODE_CLEAR:
            begin
                flags    = rx_rd;
                rx_we    = 1'b1;
                rx_wdata = rx_rd & ~item.signal_mask;
            end
            spts_pkg::MODE_READ_RX:
            begin
                flags = rx_rd;
            end
            spts_pkg::MODE_READ_EX:
            begin
                flags = ex_rd;
            end
            default:
            begin
                flags = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ready_reg <= '0;
            cur_reg   <= '0;
            for (int i = 0; i < spts_pkg::MAX_TASKS; i++) begin
                rx_reg[i] <= '0;
                ex_reg[i] <= '0;
            end
        end
        else if (fire) begin
            ready_reg <= ready_next;
            cur_reg   <= cur_next;
            if (clear_all) begin
                for (int i = 0; i < spts_pkg::MAX_TASKS; i++) begin
                    rx_reg[i] <= '0;
                    ex_reg[i] <= '0;
                end
            end
            else begin
                if (rx_we) begin
                    rx_reg[rd_idx] <= rx_wdata;
                end
                if (ex_we) begin
                    ex_reg[rd_idx] <= ex_wdata;
                end
            end
        end
    end

    always_comb
    begin
        result.running_task = cur_next;
        result.switched     = (cur_next != cur_reg);
        result.blocked      = blocked;
        result.none_ready   = none_ready;
        result.flags_out    = flags;
    end

endmodule

`default_nettype wire

[src/signal_priority_task_scheduler.sv]
// Top level of the signal priority task scheduler: input and result
// registers, task_count register. Depends on spts_pkg and spts_sched_core.
//
// Use: present a call (mode, target_task, signal_mask) with in_valid; it
// transfers when in_ready is also high. Each call yields exactly one result
// (running_task, switched, blocked, none_ready, flags_out) on the output
// channel, transferred when out_valid and out_ready are both high.
// A call that transfers is registered in the input register, executed against
// the task table from there and its result registered in the result register;
// while the receiver stalls, the call waits in the input register.
// Throughput: one call per cycle while the receiver takes results; the task
// table is read, updated and the ready map priority-encoded combinationally
// between input and result register. A stalled receiver holds the result
// register; the input register still takes one more call, then in_ready
// drops until the result moves. task_count is set through cfg_wr_en and
// cfg_wr_data; the user must write it only while no call is in flight, and
// the block does not enforce this. Reset clears all flags, the ready map,
// the running index and task_count, and empties both registers.
`default_nettype none

module signal_priority_task_scheduler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  mode,
    input  wire logic [4:0]  target_task,
    input  wire logic [15:0] signal_mask,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       running_task,
    output logic             switched,
    output logic             blocked,
    output logic             none_ready,
    output logic [15:0]      flags_out,
    input  wire logic        cfg_wr_en,
    input  wire logic [4:0]  cfg_wr_data
);

    logic                 in_valid_reg;
    spts_pkg::item_t      item_reg;
    logic                 out_valid_reg;
    spts_pkg::result_t    result_reg;
    spts_pkg::result_t    result_next;
    spts_pkg::task_idx_t  task_count_reg;
    logic                 advance;
    logic                 fire;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            task_count_reg <= '0;
        end
        else begin
            if (in_ready) begin
                in_valid_reg <= in_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_wr_en) begin
                task_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            item_reg.mode        <= mode;
            item_reg.target_task <= target_task;
            item_reg.signal_mask <= signal_mask;
        end
        if (fire) begin
            result_reg <= result_next;
        end
    end

    spts_sched_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (item_reg),
        .task_count (task_count_reg),
        .result     (result_next)
    );

    assign out_valid    = out_valid_reg;
    assign running_task = result_reg.running_task;
    assign switched     = result_reg.switched;
    assign blocked      = result_reg.blocked;
    assign none_ready   = result_reg.none_ready;
    assign flags_out    = result_reg.flags_out;

endmodule

`default_nettype wire

[src/spts_checker.sv]
// Port-level checker for the signal priority task scheduler, bound to the
// top level. Depends on nothing but the top level's ports.
`default_nettype none

module spts_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [4:0]  running_task,
    input wire logic        switched,
    input wire logic        blocked,
    input wire logic        none_ready,
    input wire logic [15:0] flags_out
);

    logic [4:0] last_running_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_running_reg <= '0;
        end
        else if (out_valid && out_ready) begin
            last_running_reg <= running_task;
        end
    end

    a_stall_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_stall_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(running_task) && $stable(flags_out))
        else $error("result changed while stalled");

    a_idle_only_on_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && none_ready |-> blocked)
        else $error("idle election without a blocking wait");

    a_no_switch_same_task: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !switched |-> running_task == last_running_reg)
        else $error("running task moved without a switch");

endmodule

bind signal_priority_task_scheduler spts_checker u_spts_checker (.*);

`default_nettype wire
